[hw/rtl/stfi_pkg.sv]
// Shared types, constants and helpers of the symbol table find-or-insert unit.
package stfi_pkg;

    localparam int unsigned MAX_LOG2   = 10;
    localparam int unsigned BANK_DEPTH = 1 << MAX_LOG2;
    localparam int unsigned IDX_W      = MAX_LOG2;
    localparam int unsigned ADDR_W     = IDX_W + 1;
    localparam int unsigned KEY_W      = 32;
    localparam int unsigned HASH_W     = IDX_W;
    localparam int unsigned HANDLE_W   = 9;
    localparam int unsigned COUNT_W    = 10;
    localparam int unsigned LOG2_W     = 4;
    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned OUT_DATA_W = 16;
    localparam int unsigned OUT_USER_W = 2;
    localparam int unsigned MIN_LOG2   = 2;
    localparam int unsigned RESET_LOG2 = 3;

    // One slot of the table memory
    typedef struct packed {
        logic                valid;
        logic [KEY_W-1:0]    key;
        logic [HASH_W-1:0]   hash;
        logic [HANDLE_W-1:0] handle;
    } slot_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOOKUP,
        ST_PROBE,
        ST_GROW_CLR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_RH_PROBE,
        ST_OUT
    } state_t;

    // Index mask for a table of 2**lg slots
    function automatic logic [IDX_W-1:0] cap_mask(input logic [LOG2_W-1:0] lg);
        logic [IDX_W:0] cap;
        cap = (IDX_W+1)'(1) << lg;
        return IDX_W'(cap - (IDX_W+1)'(1));
    endfunction

    // Limit a start capacity to the supported range
    function automatic logic [LOG2_W-1:0] clamp_log2(input logic [LOG2_W-1:0] v);
        logic [LOG2_W-1:0] r;
        r = v;
        if (v < LOG2_W'(MIN_LOG2)) r = LOG2_W'(MIN_LOG2);
        if (v > LOG2_W'(MAX_LOG2)) r = LOG2_W'(MAX_LOG2);
        return r;
    endfunction

endpackage

[hw/rtl/symbol_table_find_or_insert_unit.sv]
// Open-addressed symbol table with triangular probing and ping-pong growth.
// One word at a time: a new word is taken only when idle, after the last result has moved on.
// Growth clears the other bank, reads each old slot, probes per moved entry, then retries.
// Reset and each configuration write clear bank 0 one slot at a time; no word accepted then.
// aresetn is synchronous, active low; capacity restarts at 8 slots.
module symbol_table_find_or_insert_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // start_capacity_log2 [3:0]
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [stfi_pkg::LOG2_W-1:0]         cfg_data,
    // symbol_key [31:0], symbol_hash [63:32] (only bits [41:32] used)
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [stfi_pkg::IN_DATA_W-1:0]      s_tdata,
    // var_handle [8:0], zero fill [15:9]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [stfi_pkg::OUT_DATA_W-1:0]     m_tdata,
    // was_inserted [0], table_full [1]
    output logic [stfi_pkg::OUT_USER_W-1:0]     m_tuser
);
    import stfi_pkg::*;

    slot_t mem [2*BANK_DEPTH];

    state_t state_reg, state_next;
    logic                bank_reg, bank_next;
    logic [LOG2_W-1:0]   lg_reg, lg_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [HASH_W-1:0]   hash_reg, hash_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    step_reg, step_next;
    logic [IDX_W-1:0]    ptr_reg, ptr_next;
    slot_t               mv_reg, mv_next;
    logic [HANDLE_W-1:0] res_handle_reg, res_handle_next;
    logic                res_ins_reg, res_ins_next;
    logic                res_full_reg, res_full_next;
    logic                m_valid_reg, m_valid_next;
    logic [HANDLE_W-1:0] m_handle_reg, m_handle_next;
    logic                m_ins_reg, m_ins_next;
    logic                m_full_reg, m_full_next;

    slot_t               rd_reg;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    slot_t               mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;

    logic [IDX_W-1:0]    mask;
    logic [IDX_W-1:0]    new_mask;
    logic [IDX_W:0]      half_cap;
    logic [IDX_W:0]      count_inc;
    logic [IDX_W-1:0]    idx_step;
    logic                out_free;

    assign mask      = cap_mask(lg_reg);
    assign new_mask  = cap_mask(lg_reg + LOG2_W'(1));
    assign half_cap  = ({1'b0, mask} + (IDX_W+1)'(1)) >> 1;
    assign count_inc = (IDX_W+1)'(count_reg) + (IDX_W+1)'(1);
    assign idx_step  = idx_reg + step_reg + IDX_W'(1);
    assign out_free  = !m_valid_reg || m_tready;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = OUT_DATA_W'(m_handle_reg);
    assign m_tuser   = {m_full_reg, m_ins_reg};

    // Table memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= mem[mem_raddr];
    end

    // State and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            bank_reg    <= 1'b0;
            lg_reg      <= LOG2_W'(RESET_LOG2);
            count_reg   <= '0;
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bank_reg    <= bank_next;
            lg_reg      <= lg_next;
            count_reg   <= count_next;
            ptr_reg     <= ptr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        key_reg        <= key_next;
        hash_reg       <= hash_next;
        idx_reg        <= idx_next;
        step_reg       <= step_next;
        mv_reg         <= mv_next;
        res_handle_reg <= res_handle_next;
        res_ins_reg    <= res_ins_next;
        res_full_reg   <= res_full_next;
        m_handle_reg   <= m_handle_next;
        m_ins_reg      <= m_ins_next;
        m_full_reg     <= m_full_next;
    end

    // Next state, memory accesses and results
    always_comb begin
        state_next      = state_reg;
        bank_next       = bank_reg;
        lg_next         = lg_reg;
        count_next      = count_reg;
        key_next        = key_reg;
        hash_next       = hash_reg;
        idx_next        = idx_reg;
        step_next       = step_reg;
        ptr_next        = ptr_reg;
        mv_next         = mv_reg;
        res_handle_next = res_handle_reg;
        res_ins_next    = res_ins_reg;
        res_full_next   = res_full_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_handle_next   = m_handle_reg;
        m_ins_next      = m_ins_reg;
        m_full_next     = m_full_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_raddr       = '0;

        unique case (state_reg)
            // Empty bank 0 one slot a cycle
            ST_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = {1'b0, ptr_reg};
                ptr_next  = ptr_reg + IDX_W'(1);
                if (ptr_reg == IDX_W'(BANK_DEPTH - 1)) begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            // Take one word
            ST_IDLE: begin
                if (s_tvalid) begin
                    key_next   = s_tdata[KEY_W-1:0];
                    hash_next  = s_tdata[KEY_W +: HASH_W];
                    state_next = ST_LOOKUP;
                end
            end
            // Read the home slot
            ST_LOOKUP: begin
                idx_next   = hash_reg & mask;
                step_next  = '0;
                mem_raddr  = {bank_reg, hash_reg & mask};
                state_next = ST_PROBE;
            end
            // Check one slot, then hit, insert, grow, refuse as full or step on
            ST_PROBE: begin
                if (!rd_reg.valid) begin
                    if (count_inc > half_cap) begin
                        if (lg_reg == LOG2_W'(MAX_LOG2)) begin
                            res_handle_next = '0;
                            res_ins_next    = 1'b0;
                            res_full_next   = 1'b1;
                            state_next      = ST_OUT;
                        end else begin
                            ptr_next   = '0;
                            state_next = ST_GROW_CLR;
                        end
                    end else begin
                        mem_we           = 1'b1;
                        mem_waddr        = {bank_reg, idx_reg};
                        mem_wdata.valid  = 1'b1;
                        mem_wdata.key    = key_reg;
                        mem_wdata.hash   = hash_reg;
                        mem_wdata.handle = count_reg[HANDLE_W-1:0];
                        res_handle_next  = count_reg[HANDLE_W-1:0];
                        res_ins_next     = 1'b1;
                        res_full_next    = 1'b0;
                        count_next       = count_reg + COUNT_W'(1);
                        state_next       = ST_OUT;
                    end
                end else if (rd_reg.key == key_reg) begin
                    res_handle_next = rd_reg.handle;
                    res_ins_next    = 1'b0;
                    res_full_next   = 1'b0;
                    state_next      = ST_OUT;
                end else if (step_reg == mask) begin
                    res_handle_next = '0;
                    res_ins_next    = 1'b0;
                    res_full_next   = 1'b1;
                    state_next      = ST_OUT;
                end else begin
                    idx_next  = idx_step & mask;
                    step_next = step_reg + IDX_W'(1);
                    mem_raddr = {bank_reg, idx_step & mask};
                end
            end
            // Empty the used part of the other bank
            ST_GROW_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = {!bank_reg, ptr_reg};
                ptr_next  = ptr_reg + IDX_W'(1);
                if (ptr_reg == new_mask) begin
                    ptr_next   = '0;
                    state_next = ST_SCAN_RD;
                end
            end
            // Read the next old slot
            ST_SCAN_RD: begin
                mem_raddr  = {bank_reg, ptr_reg};
                state_next = ST_SCAN_CHK;
            end
            // Move a live entry, or skip an empty slot
            ST_SCAN_CHK: begin
                if (rd_reg.valid) begin
                    mv_next    = rd_reg;
                    idx_next   = rd_reg.hash & new_mask;
                    step_next  = '0;
                    mem_raddr  = {!bank_reg, rd_reg.hash & new_mask};
                    state_next = ST_RH_PROBE;
                end else if (ptr_reg == mask) begin
                    bank_next  = !bank_reg;
                    lg_next    = lg_reg + LOG2_W'(1);
                    state_next = ST_LOOKUP;
                end else begin
                    ptr_next   = ptr_reg + IDX_W'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            // Probe the new bank for a free slot; a duplicate key or a full chain drops the entry
            ST_RH_PROBE: begin
                if (!rd_reg.valid || (rd_reg.key == mv_reg.key) || (step_reg == new_mask)) begin
                    if (!rd_reg.valid) begin
                        mem_we    = 1'b1;
                        mem_waddr = {!bank_reg, idx_reg};
                        mem_wdata = mv_reg;
                    end
                    if (ptr_reg == mask) begin
                        bank_next  = !bank_reg;
                        lg_next    = lg_reg + LOG2_W'(1);
                        state_next = ST_LOOKUP;
                    end else begin
                        ptr_next   = ptr_reg + IDX_W'(1);
                        state_next = ST_SCAN_RD;
                    end
                end else begin
                    idx_next  = idx_step & new_mask;
                    step_next = step_reg + IDX_W'(1);
                    mem_raddr = {!bank_reg, idx_step & new_mask};
                end
            end
            // Hand the result to the output register
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_handle_next = res_handle_reg;
                    m_ins_next    = res_ins_reg;
                    m_full_next   = res_full_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase

        // Register write restarts the table empty
        if (cfg_valid) begin
            lg_next    = clamp_log2(cfg_data);
            bank_next  = 1'b0;
            count_next = '0;
            ptr_next   = '0;
            state_next = ST_INIT;
        end
    end

    // A result is never both inserted and refused
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_ins_reg && m_full_reg))
        else $error("result flags inserted and full together");

    // Entry count stays within half the capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        (IDX_W+1)'(count_reg) <= half_cap)
        else $error("entry count above half capacity");

    // An insert never overwrites a live slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && (state_reg == ST_PROBE || state_reg == ST_RH_PROBE)) |-> !rd_reg.valid)
        else $error("insert over a live slot");

    // Capacity stays in the supported range
    assert property (@(posedge aclk) disable iff (!aresetn)
        (lg_reg >= LOG2_W'(MIN_LOG2)) && (lg_reg <= LOG2_W'(MAX_LOG2)))
        else $error("capacity out of range");

    // An inserted handle equals the count before the insert
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PROBE && state_next == ST_OUT && res_ins_next && !cfg_valid)
        |=> (res_handle_reg == $past(count_reg[HANDLE_W-1:0])))
        else $error("inserted handle does not match entry count");

endmodule

[sim/tb_symbol_table_find_or_insert_unit.sv]
// Self-checking bench for the symbol table find-or-insert unit: directed and random lookups.
`timescale 1ns / 100ps

module tb_symbol_table_find_or_insert_unit;
    import stfi_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned FULL_ENTRIES  = BANK_DEPTH / 2;

    typedef enum logic [1:0] {PROBE_HIT, PROBE_EMPTY, PROBE_EXHAUSTED} probe_status_t;
    typedef enum logic [1:0] {PACE_NONE, PACE_SEND, PACE_RECV, PACE_BOTH} pace_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic                inserted;
        logic                full;
    } find_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [LOG2_W-1:0]     cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    // Shadow table: two banks of slots, as the unit keeps them
    bit                  tbl_used   [2][BANK_DEPTH];
    logic [KEY_W-1:0]    tbl_key    [2][BANK_DEPTH];
    logic [31:0]         tbl_hash   [2][BANK_DEPTH];
    logic [HANDLE_W-1:0] tbl_handle [2][BANK_DEPTH];
    bit                  cur_bank;
    logic [LOG2_W-1:0]   cur_lg;
    logic [LOG2_W-1:0]   start_lg;
    logic [COUNT_W-1:0]  n_entries;

    // Keys now in the table, reused as lookups that hit
    logic [KEY_W-1:0]    known_keys[$];
    logic [31:0]         known_hashes[$];

    find_result_t        results_due[$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycle_count    = 0;
    int unsigned n_fail         = 0;
    int unsigned n_words        = 0;
    int unsigned n_inserts      = 0;
    int unsigned n_hits         = 0;
    int unsigned n_refused      = 0;
    int unsigned n_growths      = 0;
    int unsigned n_cfg_writes   = 0;

    symbol_table_find_or_insert_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Stall the result side at the rate of the current pacing mode
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Give up on a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("symbol_table_find_or_insert_unit: mismatch");
            $finish;
        end
    end

    // Compare each result word with the oldest predicted lookup
    always @(posedge aclk) begin : check_results
        find_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                $error("result word with no lookup pending: tdata %h tuser %b",
                       m_tdata, m_tuser);
                n_fail++;
            end else begin
                want = results_due.pop_front();
                if (m_tdata[HANDLE_W-1:0] !== want.handle) begin
                    $error("var_handle: expected %0d, got %0d", want.handle,
                           m_tdata[HANDLE_W-1:0]);
                    n_fail++;
                end
                if (m_tdata[OUT_DATA_W-1:HANDLE_W] !== '0) begin
                    $error("tdata zero fill: expected 0, got %h",
                           m_tdata[OUT_DATA_W-1:HANDLE_W]);
                    n_fail++;
                end
                if (m_tuser[0] !== want.inserted) begin
                    $error("was_inserted: expected %0b, got %0b", want.inserted, m_tuser[0]);
                    n_fail++;
                end
                if (m_tuser[1] !== want.full) begin
                    $error("table_full: expected %0b, got %0b", want.full, m_tuser[1]);
                    n_fail++;
                end
            end
        end
    end

    function automatic logic [LOG2_W-1:0] limit_start_log2(input logic [LOG2_W-1:0] v);
        if (v < LOG2_W'(MIN_LOG2)) return LOG2_W'(MIN_LOG2);
        if (v > LOG2_W'(MAX_LOG2)) return LOG2_W'(MAX_LOG2);
        return v;
    endfunction

    // Empty both banks and restart at the start capacity
    function automatic void reset_table();
        for (int b = 0; b < 2; b++) begin
            for (int i = 0; i < BANK_DEPTH; i++) begin
                tbl_used[b][i] = 1'b0;
            end
        end
        cur_bank  = 1'b0;
        cur_lg    = limit_start_log2(start_lg);
        n_entries = '0;
        known_keys.delete();
        known_hashes.delete();
    endfunction

    // Walk the triangular probe chain of one bank at capacity 2**lg
    function automatic probe_status_t probe_slot(input bit bank, input int unsigned lg,
                                                 input logic [KEY_W-1:0] key,
                                                 input logic [31:0] hash,
                                                 output int unsigned slot);
        int unsigned cap_n;
        int unsigned mask;
        int unsigned idx;
        cap_n = 1 << lg;
        mask  = cap_n - 1;
        idx   = hash & mask;
        slot  = 0;
        for (int unsigned n = 0; n < cap_n; n++) begin
            if (!tbl_used[bank][idx]) begin
                slot = idx;
                return PROBE_EMPTY;
            end
            if (tbl_key[bank][idx] == key) begin
                slot = idx;
                return PROBE_HIT;
            end
            idx = (idx + n + 1) & mask;
        end
        return PROBE_EXHAUSTED;
    endfunction

    // Double the capacity, rehashing each live entry that finds a free slot into the other bank
    function automatic void double_table();
        bit                src;
        bit                dst;
        int unsigned       old_cap;
        int unsigned       slot;
        logic [LOG2_W-1:0] next_lg;
        src     = cur_bank;
        dst     = !cur_bank;
        next_lg = cur_lg + 1'b1;
        old_cap = 1 << cur_lg;
        for (int i = 0; i < BANK_DEPTH; i++) begin
            tbl_used[dst][i] = 1'b0;
        end
        for (int unsigned i = 0; i < old_cap; i++) begin
            if (tbl_used[src][i] &&
                probe_slot(dst, next_lg, tbl_key[src][i], tbl_hash[src][i], slot) == PROBE_EMPTY) begin
                tbl_used[dst][slot]   = 1'b1;
                tbl_key[dst][slot]    = tbl_key[src][i];
                tbl_hash[dst][slot]   = tbl_hash[src][i];
                tbl_handle[dst][slot] = tbl_handle[src][i];
            end
        end
        cur_bank = dst;
        cur_lg   = next_lg;
        n_growths++;
    endfunction

    // Find the key, or insert it with the next handle, growing first if needed, or refuse it as full
    function automatic find_result_t predict_find_or_insert(input logic [KEY_W-1:0] key,
                                                            input logic [31:0] hash);
        find_result_t  res;
        probe_status_t status;
        int unsigned   slot;
        int unsigned   cap_n;
        res    = '0;
        cap_n  = 1 << cur_lg;
        status = probe_slot(cur_bank, cur_lg, key, hash, slot);
        if (status == PROBE_HIT) begin
            res.handle = tbl_handle[cur_bank][slot];
            n_hits++;
            return res;
        end
        if (status == PROBE_EXHAUSTED) begin
            res.full = 1'b1;
            n_refused++;
            return res;
        end
        if (n_entries + 1 > (cap_n >> 1)) begin
            if (cur_lg + 1 > MAX_LOG2) begin
                res.full = 1'b1;
                n_refused++;
                return res;
            end
            double_table();
            if (probe_slot(cur_bank, cur_lg, key, hash, slot) != PROBE_EMPTY) begin
                res.full = 1'b1;
                n_refused++;
                return res;
            end
        end
        tbl_used[cur_bank][slot]   = 1'b1;
        tbl_key[cur_bank][slot]    = key;
        tbl_hash[cur_bank][slot]   = hash;
        tbl_handle[cur_bank][slot] = n_entries[HANDLE_W-1:0];
        known_keys.push_back(key);
        known_hashes.push_back(hash);
        res.handle   = n_entries[HANDLE_W-1:0];
        res.inserted = 1'b1;
        n_entries    = n_entries + 1'b1;
        n_inserts++;
        return res;
    endfunction

    function automatic void set_pace(input pace_t mode);
        case (mode)
            PACE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            PACE_SEND: begin
                send_idle_pct  = 78;
                recv_stall_pct = 0;
            end
            PACE_RECV: begin
                send_idle_pct  = 0;
                recv_stall_pct = 78;
            end
            default: begin
                send_idle_pct  = 29;
                recv_stall_pct = 29;
            end
        endcase
    endfunction

    // Send one lookup word, predict its result, then idle per the pacing mode
    task automatic send_symbol(input logic [KEY_W-1:0] key, input logic [31:0] hash);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {hash, key};
        do @(posedge aclk); while (!s_tready);
        results_due.push_back(predict_find_or_insert(key, hash));
        n_words++;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Hold the input until every predicted result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_due.size() != 0);
    endtask

    // Load a start capacity while the unit is idle; this also empties the table
    task automatic write_start_capacity(input logic [LOG2_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        start_lg = limit_start_log2(value);
        reset_table();
        n_cfg_writes++;
    endtask

    // Default capacity of 8: hits, collisions, a repeated key under another hash, one growth
    task automatic test_reset_capacity();
        set_pace(PACE_NONE);
        send_symbol(32'h0000_0000, 32'h0000_0000);
        send_symbol(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_symbol(32'h0000_0000, 32'h0000_0000);
        send_symbol(32'h1234_5678, 32'h0000_0000);
        send_symbol(32'hFFFF_FFFF, 32'h0000_0000);
        send_symbol(32'hA5A5_A5A5, 32'h0000_0008);
        send_symbol(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_symbol(32'h1234_5678, 32'h0000_0000);
        send_symbol(32'h8000_0000, 32'h8000_0000);
        send_symbol(32'h0000_0001, 32'h0000_0001);
    endtask

    // Register extremes: below and above range clamp, then the exact upper bound
    task automatic test_register_extremes();
        write_start_capacity(LOG2_W'(0));
        send_symbol(32'h0000_0001, 32'h0000_0000);
        send_symbol(32'h0000_0002, 32'h0000_0004);
        send_symbol(32'h0000_0003, 32'h0000_0000);
        send_symbol(32'h0000_0002, 32'h0000_0004);
        write_start_capacity(LOG2_W'(15));
        send_symbol(32'hDEAD_BEEF, 32'h0000_03FF);
        send_symbol(32'hDEAD_BEEF, 32'h0000_03FF);
        send_symbol(32'h0000_0000, 32'hFFFF_FC00);
        write_start_capacity(LOG2_W'(MAX_LOG2));
        send_symbol(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_symbol(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Grow from the smallest table up to the largest and past it until inserts are refused
    task automatic test_fill_to_full();
        int unsigned past_full;
        int unsigned sent;
        int unsigned pick;
        int unsigned idx;
        logic [31:0] hot [4];
        write_start_capacity(LOG2_W'(MIN_LOG2));
        foreach (hot[i]) hot[i] = $urandom();
        past_full = 0;
        sent      = 0;
        while (past_full < 16) begin
            set_pace(pace_t'((sent / 130) % 4));
            if (sent == 260) drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 12 && known_keys.size() != 0) begin
                idx = $urandom_range(0, known_keys.size() - 1);
                send_symbol(known_keys[idx], known_hashes[idx]);
            end else if (pick < 15 && known_keys.size() != 0) begin
                // known key under a different hash
                idx = $urandom_range(0, known_keys.size() - 1);
                send_symbol(known_keys[idx], $urandom());
            end else if ($urandom_range(0, 99) < 15) begin
                send_symbol($urandom(), hot[$urandom_range(0, 3)]);
            end else begin
                send_symbol($urandom(), $urandom());
            end
            sent++;
            if (n_entries == FULL_ENTRIES) past_full++;
        end
    endtask

    // Mid-size start with hashes that share their low bits, so probe chains run long
    task automatic test_shared_hash_bits();
        logic [9:0]  low [3];
        int unsigned idx;
        write_start_capacity(LOG2_W'(5));
        foreach (low[i]) low[i] = 10'($urandom());
        for (int n = 0; n < 40; n++) begin
            set_pace(n < 20 ? PACE_BOTH : PACE_RECV);
            if ($urandom_range(0, 99) < 35 && known_keys.size() != 0) begin
                idx = $urandom_range(0, known_keys.size() - 1);
                send_symbol(known_keys[idx], known_hashes[idx]);
            end else begin
                send_symbol($urandom(), {22'($urandom()), low[$urandom_range(0, 2)]});
            end
        end
    endtask

    initial begin
        start_lg = LOG2_W'(RESET_LOG2);
        reset_table();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_capacity();
        test_register_extremes();
        test_fill_to_full();
        test_shared_hash_bits();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("ran %0d lookup words: %0d inserts, %0d hits, %0d refused as full",
                 n_words, n_inserts, n_hits, n_refused);
        $display("%0d table doublings over %0d start-capacity writes, all four pacing modes",
                 n_growths, n_cfg_writes);
        if (n_fail == 0) begin
            $display("symbol_table_find_or_insert_unit: match");
        end else begin
            $display("symbol_table_find_or_insert_unit: mismatch");
        end
        $finish;
    end

endmodule
